### hw/rtl/kid_pkg.sv
`timescale 1ns / 1ps
package kid_pkg;

   localparam int SAMPLE_BITS      = 16;
   localparam int PHASE_BITS       = 32;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
   localparam int CARRIER_BITS     = 16;
   localparam int PRODUCT_BITS     = SAMPLE_BITS + CARRIER_BITS;
   localparam int INTEG_BITS       = 48;
   localparam int POS_BITS         = 16;
   localparam int MODE_BITS        = 2;

   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE            = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP_A    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP_B    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLES_PER_BIT = 2'd3;

   localparam logic [MODE_BITS-1:0] MODE_ASK = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_PSK = 2'd1;

   localparam logic [POS_BITS-1:0] SAMPLES_PER_BIT_RESET = 16'd1000;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } stage_ctrl_type;

   typedef logic signed [CARRIER_BITS-1:0] sine_table_type [SINE_TABLE_DEPTH];

   // Quarter-wave odd polynomial in Q16, scaled to Q1.15 and rounded.
   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      longint unsigned p, q, x, x2, t, s, v;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         p = longint'(k) * 4 * 65536 / SINE_TABLE_DEPTH;
         q = (p >> 16) & 3;
         x = p & 64'hFFFF;
         if (q[0]) x = 65536 - x;
         x2 = (x * x) >> 16;
         t  = (x2 * 4926) >> 16;
         t  = 42334 - t;
         t  = (x2 * t) >> 16;
         t  = 102944 - t;
         s  = (x * t) >> 16;
         v  = (s * 32767 + 32768) >> 16;
         if (v > 32767) v = 32767;
         tbl[k] = (q >= 2) ? CARRIER_BITS'(-v) : CARRIER_BITS'(v);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

### hw/rtl/kid_slicer.sv
`timescale 1ns / 1ps
module kid_slicer
   import kid_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic [MODE_BITS-1:0]         mode,
   input  logic signed [INTEG_BITS-1:0] integ_a,
   input  logic signed [INTEG_BITS-1:0] integ_b,
   input  stage_ctrl_type               ctrl,
   output logic                         fire,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_decided_bit
);

   logic signed [INTEG_BITS:0] diff;
   logic                       decision;
   logic [POS_BITS-1:0]        ones_ff, ones_in, zeros_ff, zeros_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       bit_ff, bit_in;

   always_comb begin
      diff = (INTEG_BITS+1)'(integ_b) - (INTEG_BITS+1)'(integ_a);
      case (mode)
         MODE_ASK: decision = !integ_a[INTEG_BITS-1] && (integ_a != '0);
         MODE_PSK: decision = integ_a[INTEG_BITS-1];
         default:  decision = !diff[INTEG_BITS] && (diff != '0);  // both FSK codes
      endcase
   end

   // a word that ends the bit period needs the result register free
   assign fire = ctrl.valid && (!ctrl.last || !rsp_valid_ff || rsp_ready);

   always_comb begin
      ones_in      = ones_ff;
      zeros_in     = zeros_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         if (ctrl.last) begin
            bit_in       = !(zeros_ff > ones_ff);
            rsp_valid_in = 1'b1;
            ones_in      = '0;
            zeros_in     = '0;
         end else if (decision) begin
            ones_in = ones_ff + 1'b1;
         end else begin
            zeros_in = zeros_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_ff      <= '0;
         zeros_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ones_ff      <= ones_in;
         zeros_ff     <= zeros_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_ff <= bit_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_decided_bit = bit_ff;

`ifndef SYNTHESIS
   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      fire && ctrl.last |=> rsp_valid)
      else $error("bit period end did not raise rsp_valid");
   a_emit_clears_counts: assert property (@(posedge clock) disable iff (reset)
      fire && ctrl.last |=> ones_ff == '0 && zeros_ff == '0)
      else $error("counts not cleared after decision");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_decided_bit))
      else $error("pending decision overwritten");
`endif

endmodule

### hw/rtl/keying_integrate_dump_demodulator.sv
`timescale 1ns / 1ps
// Coherent ASK/PSK/FSK integrate-and-dump demodulator. One sample word is
// accepted per clock while rsp backpressure does not stall the pipeline; a word
// passes through four register stages (carrier lookup, multiply, integrate,
// slice), and the slice stage registers the decided bit onto rsp once the last
// sample of its bit period has reached it. Only the last sample of each period
// yields a result word. The carrier comes from a 1024-entry sine table addressed
// by the top bits of a 32-bit phase accumulator. Both integrators saturate at
// 48 bits signed. Backpressure on rsp stalls the pipeline only when the slice
// stage holds a period end and the result register is still occupied.
module keying_integrate_dump_demodulator
   import kid_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_decided_bit,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam logic signed [INTEG_BITS-1:0] INTEG_MAX = {1'b0, {(INTEG_BITS-1){1'b1}}};
   localparam logic signed [INTEG_BITS-1:0] INTEG_MIN = {1'b1, {(INTEG_BITS-1){1'b0}}};

   function automatic logic signed [INTEG_BITS-1:0] sat_add(
      input logic signed [INTEG_BITS-1:0]   acc,
      input logic signed [PRODUCT_BITS-1:0] prod);
      logic signed [INTEG_BITS:0] sum;
      sum = (INTEG_BITS+1)'(acc) + (INTEG_BITS+1)'(prod);
      if (sum[INTEG_BITS] != sum[INTEG_BITS-1])
         return sum[INTEG_BITS] ? INTEG_MIN : INTEG_MAX;
      return sum[INTEG_BITS-1:0];
   endfunction

   // configuration
   logic [MODE_BITS-1:0]  mode_ff, mode_in;
   logic [PHASE_BITS-1:0] step_a_ff, step_a_in, step_b_ff, step_b_in;
   logic [POS_BITS-1:0]   spb_ff, spb_in;

   // front end state
   logic [PHASE_BITS-1:0] phase_a_ff, phase_a_in, phase_b_ff, phase_b_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in, last_pos;
   logic                  is_first, is_last, accept;

   // pipeline
   stage_ctrl_type                 s1_ctrl_ff, s1_ctrl_in, s2_ctrl_ff, s2_ctrl_in;
   stage_ctrl_type                 s3_ctrl_ff, s3_ctrl_in;
   logic signed [SAMPLE_BITS-1:0]  s1_sample_ff, s1_sample_in;
   logic signed [CARRIER_BITS-1:0] s1_car_a_ff, s1_car_a_in, s1_car_b_ff, s1_car_b_in;
   logic signed [PRODUCT_BITS-1:0] s2_prod_a_ff, s2_prod_a_in, s2_prod_b_ff, s2_prod_b_in;
   logic signed [INTEG_BITS-1:0]   integ_a_ff, integ_a_in, integ_b_ff, integ_b_in;
   logic                           s1_ready, s2_ready, s3_ready, s3_fire;

   always_comb begin
      mode_in   = mode_ff;
      step_a_in = step_a_ff;
      step_b_in = step_b_ff;
      spb_in    = spb_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:            mode_in   = csr_wdata[MODE_BITS-1:0];
            CSR_PHASE_STEP_A:    step_a_in = csr_wdata[PHASE_BITS-1:0];
            CSR_PHASE_STEP_B:    step_b_in = csr_wdata[PHASE_BITS-1:0];
            CSR_SAMPLES_PER_BIT: spb_in    = csr_wdata[POS_BITS-1:0];
         endcase
      end
   end

   assign s3_ready  = !s3_ctrl_ff.valid || s3_fire;
   assign s2_ready  = !s2_ctrl_ff.valid || s3_ready;
   assign s1_ready  = !s1_ctrl_ff.valid || s2_ready;
   assign req_ready = s1_ready;
   assign accept    = req_valid && s1_ready;

   // a position at or past the last one ends the period (covers shortening)
   assign last_pos = spb_ff - 1'b1;
   assign is_first = (pos_ff == '0);
   assign is_last  = (pos_ff >= last_pos);

   always_comb begin
      phase_a_in   = phase_a_ff;
      phase_b_in   = phase_b_ff;
      pos_in       = pos_ff;
      s1_ctrl_in   = s1_ctrl_ff;
      s1_sample_in = s1_sample_ff;
      s1_car_a_in  = s1_car_a_ff;
      s1_car_b_in  = s1_car_b_ff;
      if (accept) begin
         // carrier uses the phase before this sample's step
         s1_car_a_in  = SINE_TABLE[phase_a_ff[PHASE_BITS-1 -: SINE_ADDR_BITS]];
         s1_car_b_in  = SINE_TABLE[phase_b_ff[PHASE_BITS-1 -: SINE_ADDR_BITS]];
         s1_sample_in = req_sample;
         s1_ctrl_in   = '{valid: 1'b1, first: is_first, last: is_last};
         phase_a_in   = phase_a_ff + step_a_ff;
         phase_b_in   = phase_b_ff + step_b_ff;
         pos_in       = is_last ? '0 : pos_ff + 1'b1;
      end else if (s2_ready) begin
         s1_ctrl_in.valid = 1'b0;
      end
   end

   always_comb begin
      s2_ctrl_in   = s2_ctrl_ff;
      s2_prod_a_in = s2_prod_a_ff;
      s2_prod_b_in = s2_prod_b_ff;
      if (s2_ready) begin
         s2_ctrl_in   = s1_ctrl_ff;
         s2_prod_a_in = s1_sample_ff * s1_car_a_ff;
         s2_prod_b_in = s1_sample_ff * s1_car_b_ff;
      end
   end

   always_comb begin
      s3_ctrl_in = s3_ctrl_ff;
      integ_a_in = integ_a_ff;
      integ_b_in = integ_b_ff;
      if (s3_ready) begin
         s3_ctrl_in = s2_ctrl_ff;
         if (s2_ctrl_ff.valid) begin
            // first sample of a period clears and drops its product
            integ_a_in = s2_ctrl_ff.first ? '0 : sat_add(integ_a_ff, s2_prod_a_ff);
            integ_b_in = s2_ctrl_ff.first ? '0 : sat_add(integ_b_ff, s2_prod_b_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_ASK;
         step_a_ff  <= '0;
         step_b_ff  <= '0;
         spb_ff     <= SAMPLES_PER_BIT_RESET;
         phase_a_ff <= '0;
         phase_b_ff <= '0;
         pos_ff     <= '0;
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
         s3_ctrl_ff <= '0;
         integ_a_ff <= '0;
         integ_b_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         step_a_ff  <= step_a_in;
         step_b_ff  <= step_b_in;
         spb_ff     <= spb_in;
         phase_a_ff <= phase_a_in;
         phase_b_ff <= phase_b_in;
         pos_ff     <= pos_in;
         s1_ctrl_ff <= s1_ctrl_in;
         s2_ctrl_ff <= s2_ctrl_in;
         s3_ctrl_ff <= s3_ctrl_in;
         integ_a_ff <= integ_a_in;
         integ_b_ff <= integ_b_in;
      end
      s1_sample_ff <= s1_sample_in;
      s1_car_a_ff  <= s1_car_a_in;
      s1_car_b_ff  <= s1_car_b_in;
      s2_prod_a_ff <= s2_prod_a_in;
      s2_prod_b_ff <= s2_prod_b_in;
   end

   kid_slicer u_slicer (
      .clock           (clock),
      .reset           (reset),
      .mode            (mode_ff),
      .integ_a         (integ_a_ff),
      .integ_b         (integ_b_ff),
      .ctrl            (s3_ctrl_ff),
      .fire            (s3_fire),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_decided_bit (rsp_decided_bit)
   );

`ifndef SYNTHESIS
   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      s3_ctrl_ff.valid && s3_ctrl_ff.first |-> integ_a_ff == '0 && integ_b_ff == '0)
      else $error("integrators not cleared on first sample");
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_ctrl_ff.valid && s2_ctrl_ff.valid && s3_ctrl_ff.valid)
      else $error("input stalled with a bubble in the pipeline");
   a_last_resets_pos: assert property (@(posedge clock) disable iff (reset)
      accept && is_last |=> pos_ff == '0)
      else $error("position not restarted after period end");
`endif

endmodule
